### hw/rtl/tod_pkg.sv
// Shared types, constants and helper functions for the time-of-day clock.
`timescale 1ns / 1ps

package tod_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_EDIT_H = 2'd1,
    MODE_EDIT_M = 2'd2,
    MODE_EDIT_S = 2'd3
  } mode_t;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REFRESH = 1'b1;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [4:0] HOUR_RESET = 5'd11;

  localparam logic [5:0] HOUR_MOD   = 6'd24;
  localparam logic [5:0] MINSEC_MOD = 6'd60;
  // Bias keeps value + delta non-negative; a multiple of the modulus.
  localparam logic signed [9:0] HOUR_BIAS   = 10'sd144;
  localparam logic signed [9:0] MINSEC_BIAS = 10'sd180;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_BLANK = 8'hFF;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  typedef struct packed {
    logic              action;
    logic [7:0]        button_presses;
    logic signed [7:0] encoder_delta;
  } in_t;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic [7:0] hour_tens_char;
    logic [7:0] hour_ones_char;
    logic [7:0] minute_tens_char;
    logic [7:0] minute_ones_char;
    logic [7:0] second_tens_char;
    logic [7:0] second_ones_char;
    logic [7:0] separator_char;
  } out_t;

  // Reduce a biased sum (0..366) modulo m with parallel threshold compares.
  function automatic logic [5:0] wrap_mod(input logic [8:0] s, input logic [5:0] m);
    logic [9:0] r;
    logic [9:0] thr;
    r = {1'b0, s};
    for (int k = 1; k < 16; k++) begin
      thr = 10'(k * int'(m));
      if ({1'b0, s} >= thr) begin
        r = {1'b0, s} - thr;
      end
    end
    return r[5:0];
  endfunction

  // Tens digit of a value 0..59.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    t = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (v >= 6'(k * 10)) begin
        t = 3'(k);
      end
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] rem;
    rem = v - 6'(tens_of(v)) * 6'd10;
    return rem[3:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return DIGIT_BASE + 8'(d);
  endfunction

endpackage

### hw/rtl/tod_core.sv
// Time and mode state with the per-beat update and display formatting.
`timescale 1ns / 1ps

module tod_core import tod_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  in_t  in_beat,
  output logic res_vld,
  output out_t res
);

  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  mode_t      mode_r, mode_nxt;
  logic       blink_r, blink_nxt;

  logic              b1;
  mode_t             mode_new;
  logic signed [9:0] sum_h, sum_m, sum_s;
  logic [5:0]        hour6;
  logic [7:0]        ch [6];

  assign b1       = blink_r ^ (|in_beat.button_presses);
  assign mode_new = mode_t'(mode_r + in_beat.button_presses[1:0]);
  assign sum_h    = $signed({5'b0, hour_r}) + 10'(in_beat.encoder_delta) + HOUR_BIAS;
  assign sum_m    = $signed({4'b0, min_r}) + 10'(in_beat.encoder_delta) + MINSEC_BIAS;
  assign sum_s    = $signed({4'b0, sec_r}) + 10'(in_beat.encoder_delta) + MINSEC_BIAS;
  assign hour6    = wrap_mod(sum_h[8:0], HOUR_MOD);

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    mode_nxt  = mode_r;
    blink_nxt = blink_r;
    if (accept) begin
      if (in_beat.action == ACT_TICK) begin
        if (mode_r == MODE_NORMAL) begin
          if (sec_r >= MINSEC_MAX) begin
            sec_nxt = '0;
            if (min_r >= MINSEC_MAX) begin
              min_nxt  = '0;
              hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end
      end else begin
        mode_nxt  = mode_new;
        blink_nxt = ~b1;
        case (mode_new)
          MODE_EDIT_H: hour_nxt = hour6[4:0];
          MODE_EDIT_M: min_nxt  = wrap_mod(sum_m[8:0], MINSEC_MOD);
          MODE_EDIT_S: sec_nxt  = wrap_mod(sum_s[8:0], MINSEC_MOD);
          default: ;
        endcase
      end
    end
  end

  // Display formatting from the updated time.
  always_comb begin
    ch[0] = digit_char({1'b0, tens_of({1'b0, hour_nxt})});
    ch[1] = digit_char(ones_of({1'b0, hour_nxt}));
    ch[2] = digit_char({1'b0, tens_of(min_nxt)});
    ch[3] = digit_char(ones_of(min_nxt));
    ch[4] = digit_char({1'b0, tens_of(sec_nxt)});
    ch[5] = digit_char(ones_of(sec_nxt));
    res.separator_char = CHAR_COLON;
    case (mode_new)
      MODE_NORMAL: res.separator_char = b1 ? CHAR_COLON : CHAR_SPACE;
      MODE_EDIT_H: if (!b1) begin
        ch[0] = CHAR_BLANK;
        ch[1] = CHAR_BLANK;
      end
      MODE_EDIT_M: if (!b1) begin
        ch[2] = CHAR_BLANK;
        ch[3] = CHAR_BLANK;
      end
      MODE_EDIT_S: if (!b1) begin
        ch[4] = CHAR_BLANK;
        ch[5] = CHAR_BLANK;
      end
      default: ;
    endcase
    res.mode             = mode_new;
    res.hour_value       = hour_nxt;
    res.minute_value     = min_nxt;
    res.second_value     = sec_nxt;
    res.hour_tens_char   = ch[0];
    res.hour_ones_char   = ch[1];
    res.minute_tens_char = ch[2];
    res.minute_ones_char = ch[3];
    res.second_tens_char = ch[4];
    res.second_ones_char = ch[5];
  end

  assign res_vld = accept && (in_beat.action == ACT_REFRESH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= HOUR_RESET;
      mode_r  <= MODE_NORMAL;
      blink_r <= 1'b0;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      mode_r  <= mode_nxt;
      blink_r <= blink_nxt;
    end
  end

endmodule

### hw/rtl/tod_outreg.sv
// Output register for result beats; frees itself as the beat drains.
`timescale 1ns / 1ps

module tod_outreg import tod_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_vld,
  input  out_t res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t data_r;

  assign can_load      = !out_valid_r || out_ready;
  assign out_valid_nxt = res_vld || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/time_of_day_clock_with_set_mode.sv
// Top level of the 24-hour time-of-day clock with time-set mode.
`timescale 1ns / 1ps
// A refresh beat shows on out_* in the cycle after acceptance; ticks give no beat.
// Throughput: one input beat per cycle; in_ready is low only while a result beat
//   sits in the output register and out_ready is low.
// Reset (rst_n, synchronous, active low): time 11:00:00, normal mode, blink phase 0,
//   output register empty.

module time_of_day_clock_with_set_mode import tod_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic accept;
  logic res_vld;
  out_t res;
  logic can_load;

  // Ticks also wait for a free output slot, which keeps the beat order simple.
  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  // State update and display formatting, all in the accepting cycle.
  tod_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_beat (in_data),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register; loads whenever empty or being drained this cycle.
  tod_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/tod_checker.sv
// Port-level checks for the time-of-day clock, bound to the top level.
`timescale 1ns / 1ps

module tod_checker import tod_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hour_value <= HOUR_MAX && out_data.minute_value <= MINSEC_MAX
                  && out_data.second_value <= MINSEC_MAX)
    else $error("time field out of range");

  a_sep_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode != MODE_NORMAL |-> out_data.separator_char == CHAR_COLON)
    else $error("edit mode must show colon");

  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_TICK && !out_valid |=> !out_valid)
    else $error("tick produced a result beat");

endmodule

bind time_of_day_clock_with_set_mode tod_checker u_tod_checker (.*);
